// File: sv/pan_tilt_target_tracker_assert.svh
// assertion macros for the pan/tilt target tracker
// included by pan_tilt_target_tracker.sv, expects i_clk and i_rst_n in scope
`ifndef PAN_TILT_TARGET_TRACKER_ASSERT_SVH
`define PAN_TILT_TARGET_TRACKER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PTT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tracker check failed");

// antecedent implies consequent in the next cycle
`define PTT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tracker check failed");

`endif

// File: sv/ptt_pkg.sv
// constants and register codes for the pan/tilt target tracker
// no dependencies; used by pan_tilt_target_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

package ptt_pkg;

    localparam int ANGLE_W   = 20;  // Q4.16 radians
    localparam int OFFSET_W  = 24;  // Q8.16 position
    localparam int GAIN_W    = 16;  // Q0.16
    localparam int STEP_W    = 19;
    localparam int THRESH_W  = 23;
    localparam int AGE_W     = 16;
    localparam int TIMEOUT_W = 15;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 23;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 40;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RETURN_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_MAX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_MIN   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd7;

    // reset values
    localparam logic [GAIN_W-1:0]           RST_GAIN        = 16'd1311;
    localparam logic [THRESH_W-1:0]         RST_THRESHOLD   = 23'd6554;
    localparam logic [STEP_W-1:0]           RST_MAX_STEP    = 19'd1716;
    localparam logic [STEP_W-1:0]           RST_RETURN_STEP = 19'd572;
    localparam logic [STEP_W-1:0]           RST_YAW_LIMIT   = 19'd137258;
    localparam logic signed [ANGLE_W-1:0]   RST_PITCH_MAX   = 20'sd80068;
    localparam logic signed [ANGLE_W-1:0]   RST_PITCH_MIN   = -20'sd37746;
    localparam logic [TIMEOUT_W-1:0]        RST_TIMEOUT     = 15'd1000;

    // one input word after unpacking
    typedef struct packed {
        logic                         state_present;
        logic [1:0]                   joint_count;
        logic signed [ANGLE_W-1:0]    current_yaw;
        logic signed [ANGLE_W-1:0]    current_pitch;
        logic                         object_present;
        logic signed [AGE_W-1:0]      detect_age_ms;
        logic signed [OFFSET_W-1:0]   point_x;
        logic signed [OFFSET_W-1:0]   point_y;
    } t_in_item;

    // step stage result handed to the target update stage
    typedef struct packed {
        logic                         seen;
        logic                         two_joints;
        logic signed [ANGLE_W-1:0]    cur_yaw;
        logic signed [ANGLE_W-1:0]    cur_pitch;
        logic signed [ANGLE_W-1:0]    d_yaw;
        logic signed [ANGLE_W-1:0]    d_pitch;
    } t_step_item;

endpackage

`default_nettype wire

// File: sv/pan_tilt_target_tracker.sv
// pan/tilt target tracker: proportional two-axis tracking with return to home
// depends on ptt_pkg.sv and pan_tilt_target_tracker_assert.svh
`timescale 1ns / 1ps
`default_nettype none

// One input word is one control tick. The block takes a word in every cycle it
// is ready and, when the tick yields a result, presents it once the word has
// passed an input register, a step stage (absolute offset, one 24x16 multiply
// per axis, rounding, dead band and step limit) and a target update stage that
// applies the step or the return slew to the stored targets and clamps them.
// Only the update stage reads the stored targets, so ticks follow back to back
// at one per cycle unless the output stalls. Ticks without joint state, or with
// a joint count other than one or two, produce no output word and leave the
// targets alone. Each stage holds its word only while the stage after it is
// full and stalled, so the input keeps taking words while a result waits, as
// long as a stage is free. Configuration registers are written through the cfg
// channel, which is always ready; write them only while no tick is in flight.
module pan_tilt_target_tracker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [0] state_present, [2:1] joint_count, [22:3] current_yaw,
    // [42:23] current_pitch, [43] object_present, [59:44] detect_age_ms,
    // [83:60] point_x, [107:84] point_y, [111:108] zero
    input  wire logic [ptt_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [19:0] target_yaw, [39:20] target_pitch
    output logic [ptt_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [ptt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ptt_pkg::CFG_DAT_W-1:0]  i_cfg_data
);

    // configuration registers
    logic [ptt_pkg::GAIN_W-1:0]          r_gain;
    logic [ptt_pkg::THRESH_W-1:0]        r_threshold;
    logic [ptt_pkg::STEP_W-1:0]          r_max_step;
    logic [ptt_pkg::STEP_W-1:0]          r_return_step;
    logic [ptt_pkg::STEP_W-1:0]          r_yaw_limit;
    logic signed [ptt_pkg::ANGLE_W-1:0]  r_pitch_max;
    logic signed [ptt_pkg::ANGLE_W-1:0]  r_pitch_min;
    logic [ptt_pkg::TIMEOUT_W-1:0]       r_timeout;

    // tracker state
    logic signed [ptt_pkg::ANGLE_W-1:0]  r_yaw;
    logic signed [ptt_pkg::ANGLE_W-1:0]  r_pitch;
    logic                                r_seeded;

    // pipeline
    logic                  r_a_valid;
    ptt_pkg::t_in_item     r_a;
    logic                  r_b_valid;
    ptt_pkg::t_step_item   r_b;
    logic                  r_o_valid;
    logic [ptt_pkg::OUT_DATA_W-1:0] r_o_data;

    logic                  c_en;
    logic                  b_en;
    logic                  a_en;
    logic                  a_active;
    ptt_pkg::t_in_item     in_item;
    ptt_pkg::t_step_item   n_b;
    logic signed [ptt_pkg::ANGLE_W-1:0] n_yaw;
    logic signed [ptt_pkg::ANGLE_W-1:0] n_pitch;

    // |x| of a Q8.16 offset; the most negative value gives 2^23 unsigned
    function automatic logic [ptt_pkg::OFFSET_W-1:0] f_abs(
        input logic signed [ptt_pkg::OFFSET_W-1:0] x
    );
        logic [ptt_pkg::OFFSET_W-1:0] u;
        begin
            u = $unsigned(x);
            f_abs = x[ptt_pkg::OFFSET_W-1] ? (~u + 24'd1) : u;
        end
    endfunction

    // signed step: gain times magnitude, rounded, limited, zero inside the dead band
    function automatic logic signed [ptt_pkg::ANGLE_W-1:0] f_track_delta(
        input logic [ptt_pkg::OFFSET_W-1:0] mag,
        input logic                         up,
        input logic [ptt_pkg::GAIN_W-1:0]   gain,
        input logic [ptt_pkg::THRESH_W-1:0] thr,
        input logic [ptt_pkg::STEP_W-1:0]   max_step
    );
        logic [39:0] prod;
        logic [40:0] rnd;
        logic [24:0] stp;
        logic [ptt_pkg::STEP_W-1:0] lim;
        logic signed [ptt_pkg::ANGLE_W-1:0] pos;
        begin
            prod = 40'(mag) * 40'(gain);
            rnd  = {1'b0, prod} + 41'd32768;
            stp  = rnd[40:16];
            lim  = (stp > {6'd0, max_step}) ? max_step : stp[ptt_pkg::STEP_W-1:0];
            pos  = $signed({1'b0, lim});
            if (mag <= {1'b0, thr}) begin
                f_track_delta = '0;
            end else if (up) begin
                f_track_delta = pos;
            end else begin
                f_track_delta = -pos;
            end
        end
    endfunction

    // slew toward zero by the return step, snapping when within one step
    function automatic logic signed [20:0] f_return(
        input logic signed [ptt_pkg::ANGLE_W-1:0] t,
        input logic [ptt_pkg::STEP_W-1:0]         rs
    );
        logic signed [20:0] t21;
        logic signed [20:0] rs21;
        begin
            t21  = 21'(t);
            rs21 = $signed({2'b00, rs});
            if (t21 > rs21) begin
                f_return = t21 - rs21;
            end else if (t21 < -rs21) begin
                f_return = t21 + rs21;
            end else begin
                f_return = '0;
            end
        end
    endfunction

    // configuration writes, always accepted
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain        <= ptt_pkg::RST_GAIN;
            r_threshold   <= ptt_pkg::RST_THRESHOLD;
            r_max_step    <= ptt_pkg::RST_MAX_STEP;
            r_return_step <= ptt_pkg::RST_RETURN_STEP;
            r_yaw_limit   <= ptt_pkg::RST_YAW_LIMIT;
            r_pitch_max   <= ptt_pkg::RST_PITCH_MAX;
            r_pitch_min   <= ptt_pkg::RST_PITCH_MIN;
            r_timeout     <= ptt_pkg::RST_TIMEOUT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ptt_pkg::CFG_GAIN:        r_gain        <= i_cfg_data[15:0];
                ptt_pkg::CFG_THRESHOLD:   r_threshold   <= i_cfg_data[22:0];
                ptt_pkg::CFG_MAX_STEP:    r_max_step    <= i_cfg_data[18:0];
                ptt_pkg::CFG_RETURN_STEP: r_return_step <= i_cfg_data[18:0];
                ptt_pkg::CFG_YAW_LIMIT:   r_yaw_limit   <= i_cfg_data[18:0];
                ptt_pkg::CFG_PITCH_MAX:   r_pitch_max   <= $signed(i_cfg_data[19:0]);
                ptt_pkg::CFG_PITCH_MIN:   r_pitch_min   <= $signed(i_cfg_data[19:0]);
                ptt_pkg::CFG_TIMEOUT:     r_timeout     <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // stage enables: a stage moves when it is empty or the next one moves
    assign c_en       = !r_o_valid || i_m_tready;
    assign b_en       = !r_b_valid || c_en;
    assign a_en       = !r_a_valid || b_en;
    assign o_s_tready = a_en;

    // unpack the input word
    always_comb begin
        in_item.state_present  = i_s_tdata[0];
        in_item.joint_count    = i_s_tdata[2:1];
        in_item.current_yaw    = $signed(i_s_tdata[22:3]);
        in_item.current_pitch  = $signed(i_s_tdata[42:23]);
        in_item.object_present = i_s_tdata[43];
        in_item.detect_age_ms  = $signed(i_s_tdata[59:44]);
        in_item.point_x        = $signed(i_s_tdata[83:60]);
        in_item.point_y        = $signed(i_s_tdata[107:84]);
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_en) begin
            r_a_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_en && i_s_tvalid) begin
            r_a <= in_item;
        end
    end

    // step stage: tick validity, seen flag and per-axis tracking steps
    assign a_active = r_a.state_present &&
                      (r_a.joint_count == 2'd1 || r_a.joint_count == 2'd2);

    always_comb begin
        n_b.seen       = r_a.object_present &&
                         ($signed({r_a.detect_age_ms[15], r_a.detect_age_ms}) <
                          $signed({2'b00, r_timeout}));
        n_b.two_joints = (r_a.joint_count == 2'd2);
        n_b.cur_yaw    = r_a.current_yaw;
        n_b.cur_pitch  = r_a.current_pitch;
        // yaw moves up for a negative x offset
        n_b.d_yaw      = f_track_delta(f_abs(r_a.point_x), r_a.point_x[23],
                                       r_gain, r_threshold, r_max_step);
        // y is negated, so pitch moves up for a non-negative y offset
        n_b.d_pitch    = f_track_delta(f_abs(r_a.point_y), !r_a.point_y[23],
                                       r_gain, r_threshold, r_max_step);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_en) begin
            r_b_valid <= r_a_valid && a_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en && r_a_valid) begin
            r_b <= n_b;
        end
    end

    // target update stage: seed, track or return, then clamp
    always_comb begin
        logic signed [ptt_pkg::ANGLE_W-1:0] base_yaw;
        logic signed [ptt_pkg::ANGLE_W-1:0] base_pitch;
        logic signed [20:0] y21;
        logic signed [20:0] p21;
        logic signed [20:0] ylim;
        base_yaw   = r_seeded ? r_yaw : r_b.cur_yaw;
        base_pitch = r_seeded ? r_pitch : (r_b.two_joints ? r_b.cur_pitch : '0);
        if (r_b.seen) begin
            y21 = 21'(base_yaw) + 21'(r_b.d_yaw);
            p21 = 21'(base_pitch) + 21'(r_b.d_pitch);
        end else begin
            y21 = f_return(base_yaw, r_return_step);
            p21 = f_return(base_pitch, r_return_step);
        end
        ylim = $signed({2'b00, r_yaw_limit});
        if (y21 > ylim) begin
            y21 = ylim;
        end
        if (y21 < -ylim) begin
            y21 = -ylim;
        end
        // max applied last so it wins over an inverted min
        if (p21 < 21'(r_pitch_min)) begin
            p21 = 21'(r_pitch_min);
        end
        if (p21 > 21'(r_pitch_max)) begin
            p21 = 21'(r_pitch_max);
        end
        n_yaw   = y21[ptt_pkg::ANGLE_W-1:0];
        n_pitch = p21[ptt_pkg::ANGLE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw     <= '0;
            r_pitch   <= '0;
            r_seeded  <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (c_en) begin
            r_o_valid <= r_b_valid;
            if (r_b_valid) begin
                r_yaw    <= n_yaw;
                r_pitch  <= n_pitch;
                r_seeded <= 1'b1;
            end
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (c_en && r_b_valid) begin
            r_o_data <= {n_pitch, n_yaw};
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;

    // checks
    `include "pan_tilt_target_tracker_assert.svh"

    `PTT_ASSERT_NOW(a_yaw_in_limit, o_m_tvalid,
        ($signed(o_m_tdata[19:0]) <= $signed({1'b0, r_yaw_limit})) &&
        ($signed(o_m_tdata[19:0]) >= -$signed({1'b0, r_yaw_limit})))
    `PTT_ASSERT_NOW(a_pitch_capped, o_m_tvalid,
        $signed(o_m_tdata[39:20]) <= r_pitch_max)
    `PTT_ASSERT_NEXT(a_seed_sticks, r_seeded, r_seeded)
    `PTT_ASSERT_NOW(a_result_seeds, r_o_valid, r_seeded)
    `PTT_ASSERT_NOW(a_stall_full, !o_s_tready, r_a_valid && r_b_valid && r_o_valid)

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// self-checking bench for the pan/tilt target tracker: directed ticks, then random ticks
// depends on ptt_pkg.sv and the pan_tilt_target_tracker top level
`timescale 1ns / 1ps

module tb_top;

    // input word layout, lowest bit last in the list
    typedef struct packed {
        logic [3:0]           pad;
        logic signed [23:0]   point_y;
        logic signed [23:0]   point_x;
        logic signed [15:0]   detect_age_ms;
        logic                 object_present;
        logic signed [19:0]   current_pitch;
        logic signed [19:0]   current_yaw;
        logic [1:0]           joint_count;
        logic                 state_present;
    } t_tick_word;

    // shadow of the eight tracker registers
    typedef struct packed {
        logic [15:0]          gain;
        logic [22:0]          threshold;
        logic [18:0]          max_step;
        logic [18:0]          return_step;
        logic [18:0]          yaw_limit;
        logic signed [19:0]   pitch_max;
        logic signed [19:0]   pitch_min;
        logic [14:0]          timeout_ms;
    } t_tracker_cfg;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} t_rx_mode;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_s_tvalid;
    logic                              o_s_tready;
    logic [ptt_pkg::IN_DATA_W-1:0]     i_s_tdata;
    logic                              o_m_tvalid;
    logic                              i_m_tready = 1'b1;
    logic [ptt_pkg::OUT_DATA_W-1:0]    o_m_tdata;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [ptt_pkg::CFG_IDX_W-1:0]     i_cfg_index;
    logic [ptt_pkg::CFG_DAT_W-1:0]     i_cfg_data;

    // tracker shadow state, updated as each word is accepted
    t_tracker_cfg           active_cfg;
    longint                 yaw_goal;
    longint                 pitch_goal;
    bit                     goals_seeded;
    logic [39:0]            expected_targets[$];

    int                     n_errors;
    logic [39:0]            due_targets;

    // sender bursts and receiver stall pattern
    bit                     tx_bursty;
    int                     burst_left;
    t_rx_mode               rx_mode = RX_ALWAYS;
    logic [15:0]            rx_pattern = 16'hffff;
    logic [31:0]            rx_cycle = '0;

    pan_tilt_target_tracker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // result side back-pressure, chosen per phase
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        case (rx_mode)
            RX_ALWAYS: i_m_tready <= 1'b1;
            RX_RANDOM: i_m_tready <= ($urandom_range(0, 2) != 0);
            default:   i_m_tready <= rx_pattern[rx_cycle[3:0]];
        endcase
    end

    // append one expected result word at the back of the queue
    function automatic void queue_expected(input logic [39:0] w);
        expected_targets = {expected_targets, w};
    endfunction

    function automatic t_tracker_cfg make_cfg(input longint gain, input longint thr,
                                              input longint max_step, input longint ret,
                                              input longint yaw_lim, input longint p_max,
                                              input longint p_min, input longint tmo);
        t_tracker_cfg c;
        c.gain        = gain[15:0];
        c.threshold   = thr[22:0];
        c.max_step    = max_step[18:0];
        c.return_step = ret[18:0];
        c.yaw_limit   = yaw_lim[18:0];
        c.pitch_max   = p_max[19:0];
        c.pitch_min   = p_min[19:0];
        c.timeout_ms  = tmo[14:0];
        return c;
    endfunction

    function automatic t_tick_word build_tick(input longint sp, input longint cnt,
                                              input longint yaw, input longint pitch,
                                              input longint obj, input longint age,
                                              input longint x, input longint y);
        t_tick_word t;
        t = '0;
        t.state_present  = sp[0];
        t.joint_count    = cnt[1:0];
        t.current_yaw    = yaw[19:0];
        t.current_pitch  = pitch[19:0];
        t.object_present = obj[0];
        t.detect_age_ms  = age[15:0];
        t.point_x        = x[23:0];
        t.point_y        = y[23:0];
        return t;
    endfunction

    // tracking move on one axis: rounded gain times offset, dead band, step limit
    function automatic longint track_step(input longint goal, input longint offset);
        longint mag;
        longint step;
        mag = (offset < 0) ? -offset : offset;
        if (mag <= longint'(active_cfg.threshold))
            return goal;
        step = (mag * longint'(active_cfg.gain) + 32768) >>> 16;
        if (step > longint'(active_cfg.max_step))
            step = longint'(active_cfg.max_step);
        return (offset < 0) ? goal + step : goal - step;
    endfunction

    // slew toward home, snapping to zero within one step
    function automatic longint home_step(input longint goal);
        longint rs;
        rs = longint'(active_cfg.return_step);
        if (goal > rs)
            return goal - rs;
        if (goal < -rs)
            return goal + rs;
        return 0;
    endfunction

    // one control tick; returns 1 with the expected output word when the tick gives one
    function automatic bit advance_tracker(input t_tick_word t, output logic [39:0] res);
        bit     seen;
        longint lim;
        res = '0;
        if (!t.state_present || (t.joint_count != 2'd1 && t.joint_count != 2'd2))
            return 0;
        if (!goals_seeded) begin
            yaw_goal     = longint'($signed(t.current_yaw));
            pitch_goal   = (t.joint_count == 2'd2) ? longint'($signed(t.current_pitch)) : 0;
            goals_seeded = 1'b1;
        end
        // negative age is always fresh
        seen = t.object_present &&
               (longint'($signed(t.detect_age_ms)) < longint'(active_cfg.timeout_ms));
        if (seen) begin
            yaw_goal   = track_step(yaw_goal, longint'($signed(t.point_x)));
            pitch_goal = track_step(pitch_goal, -longint'($signed(t.point_y)));
        end else begin
            yaw_goal   = home_step(yaw_goal);
            pitch_goal = home_step(pitch_goal);
        end
        lim = longint'(active_cfg.yaw_limit);
        if (yaw_goal > lim)
            yaw_goal = lim;
        if (yaw_goal < -lim)
            yaw_goal = -lim;
        // lower bound first, so the upper bound wins when they cross
        if (pitch_goal < longint'(active_cfg.pitch_min))
            pitch_goal = longint'(active_cfg.pitch_min);
        if (pitch_goal > longint'(active_cfg.pitch_max))
            pitch_goal = longint'(active_cfg.pitch_max);
        res = {pitch_goal[19:0], yaw_goal[19:0]};
        return 1;
    endfunction

    // send one word, with a random gap before each new burst when tx_bursty is set
    task automatic send_tick(input t_tick_word t);
        logic [39:0] res;
        if (tx_bursty) begin
            if (burst_left == 0) begin
                i_s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= t;
        do @(posedge i_clk); while (!o_s_tready);
        if (advance_tracker(t, res))
            queue_expected(res);
    endtask

    // stop sending, let every result out, then cover ticks still in flight without one
    task automatic drain_pipeline;
        i_s_tvalid <= 1'b0;
        while (expected_targets.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // write all eight registers back to back, only called with the block idle
    task automatic load_settings(input t_tracker_cfg c);
        logic [ptt_pkg::CFG_DAT_W-1:0] vals [8];
        logic [ptt_pkg::CFG_IDX_W-1:0] idxs [8];
        idxs = '{ptt_pkg::CFG_GAIN, ptt_pkg::CFG_THRESHOLD, ptt_pkg::CFG_MAX_STEP,
                 ptt_pkg::CFG_RETURN_STEP, ptt_pkg::CFG_YAW_LIMIT, ptt_pkg::CFG_PITCH_MAX,
                 ptt_pkg::CFG_PITCH_MIN, ptt_pkg::CFG_TIMEOUT};
        vals = '{{7'd0, c.gain}, c.threshold, {4'd0, c.max_step}, {4'd0, c.return_step},
                 {4'd0, c.yaw_limit}, {3'd0, c.pitch_max}, {3'd0, c.pitch_min},
                 {8'd0, c.timeout_ms}};
        for (int k = 0; k < 8; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idxs[k];
            i_cfg_data  <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        active_cfg = c;
    endtask

    // reset values of all eight registers
    function automatic t_tracker_cfg reset_cfg;
        return make_cfg(ptt_pkg::RST_GAIN, ptt_pkg::RST_THRESHOLD, ptt_pkg::RST_MAX_STEP,
                        ptt_pkg::RST_RETURN_STEP, ptt_pkg::RST_YAW_LIMIT,
                        ptt_pkg::RST_PITCH_MAX, ptt_pkg::RST_PITCH_MIN,
                        ptt_pkg::RST_TIMEOUT);
    endfunction

    // mostly in range, sometimes at either end or at the reset value
    function automatic longint pick_value(input longint lo, input longint hi,
                                          input longint rst);
        case ($urandom_range(0, 9))
            0:       return lo;
            1:       return hi;
            2, 3:    return rst;
            default: return lo + longint'($urandom_range(0, hi - lo));
        endcase
    endfunction

    function automatic t_tracker_cfg random_cfg;
        longint p_max;
        longint p_min;
        longint tmp;
        p_max = pick_value(-524288, 524287, ptt_pkg::RST_PITCH_MAX);
        p_min = pick_value(-524288, 524287, ptt_pkg::RST_PITCH_MIN);
        // keep crossed pitch bounds as the rarer case
        if (p_min > p_max && $urandom_range(0, 3) != 0) begin
            tmp   = p_min;
            p_min = p_max;
            p_max = tmp;
        end
        return make_cfg(pick_value(0, 65535, ptt_pkg::RST_GAIN),
                        pick_value(0, 8388607, ptt_pkg::RST_THRESHOLD),
                        pick_value(0, 524287, ptt_pkg::RST_MAX_STEP),
                        pick_value(0, 524287, ptt_pkg::RST_RETURN_STEP),
                        pick_value(0, 524287, ptt_pkg::RST_YAW_LIMIT),
                        p_max, p_min,
                        pick_value(0, 32767, ptt_pkg::RST_TIMEOUT));
    endfunction

    // ages clustered around the timeout, plus negative and arbitrary ones
    function automatic longint random_age;
        longint tmo;
        tmo = longint'(active_cfg.timeout_ms);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return (tmo > 0) ? longint'($urandom_range(0, tmo - 1)) : -1;
            5:             return tmo - 1;
            6:             return tmo;
            7:             return -longint'($urandom_range(1, 32768));
            default:       return longint'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // offsets on the dead band edge, moderate ones, and full range
    function automatic longint random_offset;
        longint thr;
        longint mag;
        thr = longint'(active_cfg.threshold);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: mag = thr + longint'($urandom_range(0, 2)) - 1;
            4, 5, 6:    mag = longint'($urandom_range(0, 4 * thr + 65536));
            default:    return longint'($urandom);
        endcase
        return ($urandom_range(0, 1) != 0) ? -mag : mag;
    endfunction

    function automatic t_tick_word random_tick;
        t_tick_word t;
        int unsigned r;
        t = '0;
        r = $urandom_range(0, 99);
        if (r < 6) begin
            t.joint_count = 2'($urandom);
        end else if (r < 12) begin
            t.state_present = 1'b1;
            t.joint_count   = ($urandom_range(0, 1) != 0) ? 2'd3 : 2'd0;
        end else begin
            t.state_present = 1'b1;
            t.joint_count   = 2'($urandom_range(1, 2));
        end
        t.current_yaw    = 20'($urandom);
        t.current_pitch  = 20'($urandom);
        t.object_present = ($urandom_range(0, 9) != 0);
        t.detect_age_ms  = 16'(random_age());
        t.point_x        = 24'(random_offset());
        t.point_y        = 24'(random_offset());
        return t;
    endfunction

    // reset settings: no-result ticks, seeding, dead band edges, freshness edges
    task automatic test_default_tracking;
        send_tick(build_tick(0, 1, 100, 200, 1, 0, 100000, 100000));
        send_tick(build_tick(1, 0, 100, 200, 1, 0, 100000, 100000));
        send_tick(build_tick(1, 3, 100, 200, 1, 0, 100000, 100000));
        send_tick(build_tick(0, 3, -1, -1, 1, -1, -1, -1));
        // first valid tick seeds the targets; pitch is dropped with one joint
        send_tick(build_tick(1, longint'($urandom_range(1, 2)), 524287, -524288,
                             0, 0, 0, 0));
        send_tick(build_tick(1, 2, -524288, 524287, 1, -32768, 8388607, -8388608));
        send_tick(build_tick(1, 1, 0, 0, 1, 999, 6554, -6555));
        send_tick(build_tick(1, 2, 0, 0, 1, 999, -6555, 6554));
        send_tick(build_tick(1, 2, 0, 0, 1, 1000, 8388607, 8388607));
        send_tick(build_tick(1, 1, 0, 0, 0, -5, 100000, 100000));
        send_tick(build_tick(1, 2, 0, 0, 1, 32767, 100000, 100000));
        send_tick(build_tick(1, 1, 0, 0, 1, 0, -8388608, 8388607));
        drain_pipeline();
    endtask

    // widest settings: huge steps beyond the angle width, full return slew
    task automatic test_open_limits;
        load_settings(make_cfg(65535, 0, 524287, 524287, 524287, 524287, -524288, 32767));
        send_tick(build_tick(1, 2, 0, 0, 1, 32766, -8388608, 8388607));
        send_tick(build_tick(1, 2, 0, 0, 1, -1, -8388608, 8388607));
        send_tick(build_tick(1, 1, 0, 0, 1, -1, 8388607, -8388608));
        send_tick(build_tick(1, 2, 0, 0, 1, 32767, 8388607, -8388608));
        send_tick(build_tick(1, 1, 0, 0, 0, 0, 0, 0));
        drain_pipeline();
    endtask

    // closed settings: zero gain and steps, zero timeout, crossed pitch bounds
    task automatic test_closed_limits;
        load_settings(make_cfg(0, 8388607, 0, 0, 0, -100, 100, 0));
        send_tick(build_tick(1, 2, 0, 0, 1, -1, -8388608, -8388608));
        send_tick(build_tick(1, 1, 0, 0, 1, 0, -8388608, 8388607));
        send_tick(build_tick(1, 2, 0, 0, 1, -32768, 8388607, -8388608));
        drain_pipeline();
    endtask

    // unit gain: step rounding at the half way point
    task automatic test_step_rounding;
        load_settings(make_cfg(1, 0, 524287, 1, ptt_pkg::RST_YAW_LIMIT,
                               ptt_pkg::RST_PITCH_MAX, ptt_pkg::RST_PITCH_MIN,
                               ptt_pkg::RST_TIMEOUT));
        send_tick(build_tick(1, 2, 0, 0, 1, 0, 32768, -32768));
        send_tick(build_tick(1, 2, 0, 0, 1, 0, 32767, 32767));
        send_tick(build_tick(1, 2, 0, 0, 1, 0, -32768, 98304));
        send_tick(build_tick(1, 2, 0, 0, 0, 0, 0, 0));
        drain_pipeline();
    endtask

    // random settings per phase, random ticks, varied sender and receiver pacing
    task automatic test_random_ticks;
        t_tick_word t;
        int         live_sent;
        for (int phase = 0; phase < 10; phase++) begin
            load_settings((phase == 0) ? reset_cfg() : random_cfg());
            tx_bursty  = (phase % 3 != 0);
            rx_mode    = (phase % 3 == 0) ? RX_ALWAYS :
                         (($urandom_range(0, 1) != 0) ? RX_RANDOM : RX_PATTERN);
            rx_pattern = 16'($urandom) | 16'h0001;
            live_sent  = 0;
            while (live_sent < 100) begin
                t = random_tick();
                send_tick(t);
                if (t.state_present && (t.joint_count == 2'd1 || t.joint_count == 2'd2))
                    live_sent++;
            end
            drain_pipeline();
        end
    endtask

    // compare every result word with the oldest expected one
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            if (expected_targets.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result word yaw %0d pitch %0d", $time,
                         $signed(o_m_tdata[19:0]), $signed(o_m_tdata[39:20]));
            end else begin
                due_targets = expected_targets.pop_front();
                if (o_m_tdata[19:0] !== due_targets[19:0]) begin
                    n_errors++;
                    $display("%0t: target_yaw expected %0d actual %0d", $time,
                             $signed(due_targets[19:0]), $signed(o_m_tdata[19:0]));
                end
                if (o_m_tdata[39:20] !== due_targets[39:20]) begin
                    n_errors++;
                    $display("%0t: target_pitch expected %0d actual %0d", $time,
                             $signed(due_targets[39:20]), $signed(o_m_tdata[39:20]));
                end
            end
        end
    end

    // main sequence
    initial begin
        i_rst_n      <= 1'b0;
        i_s_tvalid   <= 1'b0;
        i_s_tdata    <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= ptt_pkg::CFG_GAIN;
        i_cfg_data   <= '0;
        n_errors     = 0;
        burst_left   = 0;
        tx_bursty    = 1'b1;
        yaw_goal     = 0;
        pitch_goal   = 0;
        goals_seeded = 1'b0;
        active_cfg   = reset_cfg();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_tracking();
        test_open_limits();
        test_closed_limits();
        test_step_rounding();
        test_random_ticks();
        drain_pipeline();

        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
